### rtl/core/nptd_pkg.sv
`timescale 1ns / 1ps
package nptd_pkg;
  localparam int POINT_DEPTH = 4096;
  localparam int IDX_W = $clog2(POINT_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int COORD_W = 16;
  localparam int SQ_W = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int NUM_W = 2 * DIST_W;
  localparam int FRAC_W = 2 * (COORD_W - 1);
  localparam int DC_W = 8;
  localparam int DCSQ_W = 2 * DC_W;
  localparam int HITP_W = DIST_W + DCSQ_W;
  localparam logic [HITP_W-1:0] ONE = HITP_W'(1) << FRAC_W;
  localparam logic [2:0] ADDR_DIV_COUNT = 3'd0;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } item_t;
endpackage

### rtl/core/nptd_front.sv
`timescale 1ns / 1ps
module nptd_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] kind,
  input  logic [nptd_pkg::COORD_W-1:0] coord_x,
  input  logic [nptd_pkg::COORD_W-1:0] coord_y,
  input  logic [nptd_pkg::COORD_W-1:0] coord_z,
  output logic busy,
  output logic q_valid,
  output nptd_pkg::item_t q_item,
  input  logic q_pop
);
  nptd_pkg::item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;

  assign busy = (fill == 2'd2);
  assign push = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: nptd_pkg::kind_t'(kind), x: coord_x, y: coord_y, z: coord_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end
endmodule

### rtl/core/nptd_dist.sv
`timescale 1ns / 1ps
module nptd_dist (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [nptd_pkg::IDX_W-1:0] in_idx,
  input  logic [nptd_pkg::COORD_W-1:0] px,
  input  logic [nptd_pkg::COORD_W-1:0] py,
  input  logic [nptd_pkg::COORD_W-1:0] pz,
  input  logic [nptd_pkg::COORD_W-1:0] dx,
  input  logic [nptd_pkg::COORD_W-1:0] dy,
  input  logic [nptd_pkg::COORD_W-1:0] dz,
  input  logic [nptd_pkg::DIST_W-1:0] dd,
  output logic out_valid,
  output logic [nptd_pkg::IDX_W-1:0] out_idx,
  output logic [nptd_pkg::DIST_W-1:0] out_q
);
  localparam int DW = nptd_pkg::DIST_W;
  localparam int SW = nptd_pkg::SQ_W;
  localparam int NW = nptd_pkg::NUM_W;

  logic v1, v2, v3;
  logic [nptd_pkg::IDX_W-1:0] i1, i2, i3;
  logic [SW-1:0] m [6];
  logic [DW-1:0] pp, dp;
  logic [NW-1:0] pa, pb;

  logic dv [DW+1];
  logic [nptd_pkg::IDX_W-1:0] di [DW+1];
  logic [DW-1:0] dr [DW+1];
  logic [DW-1:0] dn [DW+1];
  logic [DW-1:0] dq [DW+1];
  logic [DW:0] dt [DW];
  logic dge [DW];

  always_comb begin
    for (int k = 0; k < DW; k++) begin
      dt[k] = {dr[k], dn[k][DW-1]};
      dge[k] = (dt[k] >= {1'b0, dd});
    end
  end

  always_ff @(posedge clk) begin
    m[0] <= px * px;
    m[1] <= py * py;
    m[2] <= pz * pz;
    m[3] <= px * dx;
    m[4] <= py * dy;
    m[5] <= pz * dz;
    i1 <= in_idx;
    pp <= DW'(m[0]) + DW'(m[1]) + DW'(m[2]);
    dp <= DW'(m[3]) + DW'(m[4]) + DW'(m[5]);
    i2 <= i1;
    pa <= pp * dd;
    pb <= dp * dp;
    i3 <= i2;
    dr[0] <= pa[NW-1:DW] - pb[NW-1:DW] - DW'(pa[DW-1:0] < pb[DW-1:0]);
    dn[0] <= pa[DW-1:0] - pb[DW-1:0];
    dq[0] <= '0;
    di[0] <= i3;
    for (int k = 0; k < DW; k++) begin
      dr[k+1] <= dge[k] ? DW'(dt[k] - {1'b0, dd}) : dt[k][DW-1:0];
      dn[k+1] <= {dn[k][DW-2:0], 1'b0};
      dq[k+1] <= {dq[k][DW-2:0], dge[k]};
      di[k+1] <= di[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        dv[k] <= 1'b0;
      end
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      dv[0] <= v3;
      for (int k = 0; k < DW; k++) begin
        dv[k+1] <= dv[k];
      end
    end
  end

  assign out_valid = dv[DW];
  assign out_idx = di[DW];
  assign out_q = dq[DW];
endmodule

### rtl/core/nptd_back.sv
`timescale 1ns / 1ps
module nptd_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  nptd_pkg::item_t q_item,
  output logic q_pop,
  input  logic [nptd_pkg::DC_W-1:0] div_count,
  output logic done,
  output logic hit,
  output logic [nptd_pkg::IDX_W-1:0] point_index,
  output logic [nptd_pkg::COORD_W-1:0] point_x,
  output logic [nptd_pkg::COORD_W-1:0] point_y,
  output logic [nptd_pkg::COORD_W-1:0] point_z,
  output logic [nptd_pkg::DIST_W-1:0] dist_sq
);
  localparam int CW = nptd_pkg::COORD_W;
  localparam int IW = nptd_pkg::IDX_W;
  localparam int NC = nptd_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SUM, S_CHECK, S_SCAN, S_DRAIN, S_FETCH, S_OUT
  } state_t;

  state_t state;
  logic [3*CW-1:0] mem [nptd_pkg::POINT_DEPTH];
  logic [3*CW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic wr_en;
  logic [NC-1:0] count;
  logic [NC-1:0] idx;
  logic [NC-1:0] pending;
  logic [CW-1:0] dir_x, dir_y, dir_z;
  logic [nptd_pkg::SQ_W-1:0] dsq [3];
  logic [nptd_pkg::DIST_W-1:0] dd;
  logic rd_valid;
  logic [IW-1:0] rd_idx;
  logic found;
  logic [nptd_pkg::DIST_W-1:0] best_q;
  logic [IW-1:0] best_idx;
  logic [nptd_pkg::DCSQ_W-1:0] dc_sq;
  logic res_valid;
  logic [IW-1:0] res_idx;
  logic [nptd_pkg::DIST_W-1:0] res_q;
  logic [nptd_pkg::HITP_W-1:0] hit_prod;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign wr_en = q_pop && (q_item.kind == nptd_pkg::KIND_LOAD)
                 && (count < NC'(nptd_pkg::POINT_DEPTH));
  assign rd_addr = (state == S_FETCH) ? best_idx : idx[IW-1:0];
  assign hit_prod = best_q * dc_sq;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= {q_item.x, q_item.y, q_item.z};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  nptd_dist u_dist (
    .clk(clk), .rst(rst),
    .in_valid(rd_valid), .in_idx(rd_idx),
    .px(rd_data[3*CW-1:2*CW]), .py(rd_data[2*CW-1:CW]), .pz(rd_data[CW-1:0]),
    .dx(dir_x), .dy(dir_y), .dz(dir_z), .dd(dd),
    .out_valid(res_valid), .out_idx(res_idx), .out_q(res_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx <= '0;
      pending <= '0;
      rd_valid <= 1'b0;
      found <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      rd_valid <= (state == S_SCAN);
      rd_idx <= idx[IW-1:0];
      dc_sq <= div_count * div_count;
      if (res_valid) begin
        pending <= pending - NC'(1);
        if (!found || res_q < best_q) begin
          found <= 1'b1;
          best_q <= res_q;
          best_idx <= res_idx;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_item.kind)
              nptd_pkg::KIND_LOAD: begin
                if (wr_en) begin
                  count <= count + NC'(1);
                end
              end
              nptd_pkg::KIND_CLEAR: count <= '0;
              nptd_pkg::KIND_QUERY: begin
                dir_x <= q_item.x;
                dir_y <= q_item.y;
                dir_z <= q_item.z;
                state <= S_SQ;
              end
              default: ;
            endcase
          end
        end
        S_SQ: begin
          dsq[0] <= dir_x * dir_x;
          dsq[1] <= dir_y * dir_y;
          dsq[2] <= dir_z * dir_z;
          state <= S_SUM;
        end
        S_SUM: begin
          dd <= nptd_pkg::DIST_W'(dsq[0]) + nptd_pkg::DIST_W'(dsq[1])
                + nptd_pkg::DIST_W'(dsq[2]);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (dd == '0 || count == '0) begin
            done <= 1'b1;
            hit <= 1'b0;
            point_index <= '0;
            point_x <= '0;
            point_y <= '0;
            point_z <= '0;
            dist_sq <= '0;
            state <= S_IDLE;
          end else begin
            idx <= '0;
            pending <= count;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + NC'(1);
          if (idx == count - NC'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pending == '0) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_OUT;
        S_OUT: begin
          done <= 1'b1;
          hit <= (hit_prod < nptd_pkg::ONE);
          point_index <= best_idx;
          point_x <= rd_data[3*CW-1:2*CW];
          point_y <= rd_data[2*CW-1:CW];
          point_z <= rd_data[CW-1:0];
          dist_sq <= best_q;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/nearest_point_to_direction.sv
`timescale 1ns / 1ps
// Nearest stored point to a ray through the origin along a direction.
// Commands enter on start with kind and three Q1.15 coordinates; a word is
// taken at a clock edge where start is high and busy is low. Busy rises
// when the two-entry command queue is full.
// A load writes the next store entry unless the store is full, and a
// clear empties the store; neither gives a result.
// A query gives one result word, marked by done for exactly one cycle.
// The store is read one entry per cycle into a distance pipeline with a
// 34-stage divider, and the winner is read back once the pipeline has
// drained. A zero direction or an empty store answers with an all-zero
// miss and no scan.
// The receiver cannot stall; results are never held back.
// Reset empties the store and the queue and sets div_count to 15. The
// div_count register is written over the APB port at address 0.
module nearest_point_to_direction (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] kind,
  input  logic [nptd_pkg::COORD_W-1:0] coord_x,
  input  logic [nptd_pkg::COORD_W-1:0] coord_y,
  input  logic [nptd_pkg::COORD_W-1:0] coord_z,
  output logic done,
  output logic hit,
  output logic [nptd_pkg::IDX_W-1:0] point_index,
  output logic [nptd_pkg::COORD_W-1:0] point_x,
  output logic [nptd_pkg::COORD_W-1:0] point_y,
  output logic [nptd_pkg::COORD_W-1:0] point_z,
  output logic [nptd_pkg::DIST_W-1:0] dist_sq,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [nptd_pkg::DC_W-1:0] div_count;
  logic q_valid;
  logic q_pop;
  nptd_pkg::item_t q_item;

  assign pready = 1'b1;
  assign prdata = (paddr == nptd_pkg::ADDR_DIV_COUNT) ? {24'd0, div_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= 8'd15;
    end else if (psel && penable && pwrite && paddr == nptd_pkg::ADDR_DIV_COUNT) begin
      div_count <= pwdata[nptd_pkg::DC_W-1:0];
    end
  end

  nptd_front u_front (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .busy(busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  nptd_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .div_count(div_count), .done(done), .hit(hit), .point_index(point_index),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .dist_sq(dist_sq)
  );
endmodule

### sim/nptd_checker.sv
`timescale 1ns / 1ps
module nptd_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic [1:0] kind,
  input  logic [nptd_pkg::COORD_W-1:0] coord_x,
  input  logic [nptd_pkg::COORD_W-1:0] coord_y,
  input  logic [nptd_pkg::COORD_W-1:0] coord_z,
  input  logic done,
  input  logic hit,
  input  logic [nptd_pkg::IDX_W-1:0] point_index,
  input  logic [nptd_pkg::COORD_W-1:0] point_x,
  input  logic [nptd_pkg::COORD_W-1:0] point_y,
  input  logic [nptd_pkg::COORD_W-1:0] point_z,
  input  logic [nptd_pkg::DIST_W-1:0] dist_sq,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic pready,
  output int errors,
  output int pending
);
  import nptd_pkg::*;

  typedef bit [127:0] wide_t;

  typedef struct {
    bit hit;
    bit [IDX_W-1:0] idx;
    bit [COORD_W-1:0] x;
    bit [COORD_W-1:0] y;
    bit [COORD_W-1:0] z;
    bit [DIST_W-1:0] dist_val;
  } answer_t;

  bit [COORD_W-1:0] store_x [POINT_DEPTH];
  bit [COORD_W-1:0] store_y [POINT_DEPTH];
  bit [COORD_W-1:0] store_z [POINT_DEPTH];
  int stored;
  bit [DC_W-1:0] div_count;
  answer_t answers_due [$];

  function automatic wide_t dot(bit [COORD_W-1:0] ax, bit [COORD_W-1:0] ay,
                                bit [COORD_W-1:0] az, bit [COORD_W-1:0] bx,
                                bit [COORD_W-1:0] by, bit [COORD_W-1:0] bz);
    return wide_t'(ax) * wide_t'(bx) + wide_t'(ay) * wide_t'(by) +
           wide_t'(az) * wide_t'(bz);
  endfunction

  function automatic answer_t nearest(bit [COORD_W-1:0] dx, bit [COORD_W-1:0] dy,
                                      bit [COORD_W-1:0] dz);
    answer_t a;
    wide_t dd, pp, dp, q, best_q;
    int best;
    a = '{default: 0};
    dd = dot(dx, dy, dz, dx, dy, dz);
    best = 0;
    best_q = 0;
    if (dd == 0 || stored == 0) return a;
    for (int i = 0; i < stored; i++) begin
      pp = dot(store_x[i], store_y[i], store_z[i], store_x[i], store_y[i], store_z[i]);
      dp = dot(store_x[i], store_y[i], store_z[i], dx, dy, dz);
      q = (pp * dd - dp * dp) / dd;
      if (i == 0 || q < best_q) begin
        best_q = q;
        best = i;
      end
    end
    a.hit = (best_q * wide_t'(div_count) * wide_t'(div_count)) < (wide_t'(1) << FRAC_W);
    a.idx = best[IDX_W-1:0];
    a.x = store_x[best];
    a.y = store_y[best];
    a.z = store_z[best];
    a.dist_val = best_q[DIST_W-1:0];
    return a;
  endfunction

  function automatic void compare(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      stored = 0;
      div_count = 8'd15;
      answers_due.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_DIV_COUNT) begin
        if (pwrite) div_count = pwdata[DC_W-1:0];
        else compare("prdata", div_count, prdata[DC_W-1:0]);
      end
      if (done) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected", $time);
        end else begin
          a = answers_due.pop_front();
          compare("hit", a.hit, hit);
          compare("point_index", a.idx, point_index);
          compare("point_x", a.x, point_x);
          compare("point_y", a.y, point_y);
          compare("point_z", a.z, point_z);
          compare("dist_sq", a.dist_val, dist_sq);
        end
      end
      if (start && !busy) begin
        case (kind_t'(kind))
          KIND_LOAD: begin
            if (stored < POINT_DEPTH) begin
              store_x[stored] = coord_x;
              store_y[stored] = coord_y;
              store_z[stored] = coord_z;
              stored++;
            end
          end
          KIND_QUERY: answers_due.push_back(nearest(coord_x, coord_y, coord_z));
          KIND_CLEAR: stored = 0;
          default: ;
        endcase
      end
    end
    pending = answers_due.size();
  end
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import nptd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] kind = KIND_NONE;
  logic [COORD_W-1:0] coord_x = 0, coord_y = 0, coord_z = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic busy, done, hit, pready;
  logic [IDX_W-1:0] point_index;
  logic [COORD_W-1:0] point_x, point_y, point_z;
  logic [DIST_W-1:0] dist_sq;
  logic [31:0] prdata;
  int errors, pending;
  int idle_pct;
  int words_sent;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  nearest_point_to_direction u_dut (.*);
  nptd_checker u_checker (.*);

  task automatic send(kind_t k, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    kind <= k;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (k != KIND_NONE) words_sent++;
  endtask

  task automatic drain;
    start <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic apb(logic wr, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= wr;
    paddr <= ADDR_DIV_COUNT;
    pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    @(negedge clk);
  endtask

  task automatic set_div_count(logic [7:0] value);
    drain();
    apb(1, {$urandom} & 32'hFFFF_FF00 | value);
    apb(0, 0);
  endtask

  function automatic logic [15:0] near_coord(logic [15:0] d, int sh);
    int v;
    v = int'(d >> sh) + $urandom_range(0, 3);
    return v > 16'hFFFF ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  task automatic random_phase(int items);
    logic [15:0] dx, dy, dz;
    int sh;
    words_sent = 0;
    while (words_sent < items) begin
      if ($urandom_range(99) < 15) send(KIND_CLEAR, rnd16(), rnd16(), rnd16());
      if ($urandom_range(99) < 8) send(KIND_NONE, rnd16(), rnd16(), rnd16());
      dx = rnd16();
      dy = rnd16();
      dz = rnd16();
      if ($urandom_range(99) < 20) dz = 0;
      repeat ($urandom_range(1, 12)) begin
        sh = $urandom_range(0, 3);
        if ($urandom_range(99) < 20) send(KIND_LOAD, rnd16(), rnd16(), rnd16());
        else send(KIND_LOAD, near_coord(dx, sh), near_coord(dy, sh), near_coord(dz, sh));
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(99) < 25) send(KIND_QUERY, rnd16(), rnd16(), rnd16());
        else send(KIND_QUERY, dx, dy, dz);
      end
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    send(KIND_QUERY, 16'h8000, 16'h0001, 16'h0000);
    send(KIND_LOAD, 16'h0000, 16'h0000, 16'h0000);
    send(KIND_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(KIND_LOAD, 16'h8000, 16'h0000, 16'h0000);
    send(KIND_LOAD, 16'h8000, 16'h0000, 16'h0000);
    send(KIND_QUERY, 16'h0000, 16'h0000, 16'h0000);
    send(KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(KIND_QUERY, 16'h8000, 16'h0000, 16'h0000);
    send(KIND_QUERY, 16'h0000, 16'h0000, 16'h0001);
    send(KIND_NONE, 16'h1234, 16'h5678, 16'h9ABC);
    send(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(KIND_QUERY, 16'h0001, 16'h0000, 16'h0000);
    send(KIND_LOAD, 16'hFFFF, 16'h0000, 16'h0001);
    send(KIND_LOAD, 16'h4000, 16'h4000, 16'h0000);
    send(KIND_LOAD, 16'h1000, 16'h1003, 16'h0002);
    send(KIND_QUERY, 16'h1000, 16'h1000, 16'h0000);
    send(KIND_QUERY, 16'h0000, 16'hFFFF, 16'h0000);

    set_div_count(8'd1);
    send(KIND_QUERY, 16'hFFFF, 16'h0000, 16'h0000);
    send(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send(KIND_LOAD, rnd16(), rnd16(), rnd16());
    send(KIND_LOAD, 16'h3000, 16'h1800, 16'h0C00);
    send(KIND_LOAD, 16'h3000, 16'h1800, 16'h0C00);
    send(KIND_QUERY, 16'h6000, 16'h3000, 16'h1800);
    send(KIND_QUERY, rnd16(), rnd16(), rnd16());
    send(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    random_phase(25);

    set_div_count(8'd255);
    idle_pct = 77;
    random_phase(25);

    set_div_count(8'd0);
    idle_pct = 31;
    random_phase(15);
    drain();
    random_phase(10);

    set_div_count(8'd7);
    idle_pct = 0;
    random_phase(25);

    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
